@@ rtl/ring_arc_span_generator_assert.svh @@
// Assertion helpers for the ring arc span generator.
`ifndef RING_ARC_SPAN_GENERATOR_ASSERT_SVH
`define RING_ARC_SPAN_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define RASG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RASG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RASG_ASSERT(lbl, clk, rst_n, prop, msg)
`define RASG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/rasg_pkg.sv @@
package rasg_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_LEFT   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_RIGHT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_TOP    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_BOTTOM = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LINE_STRIDE = 3'd4;

  // Quadrant mask bits
  localparam int unsigned QM_HIDE_TOP    = 0;
  localparam int unsigned QM_HIDE_BOTTOM = 1;
  localparam int unsigned QM_HIDE_LEFT   = 2;
  localparam int unsigned QM_HIDE_RIGHT  = 3;

  localparam int unsigned ColorW       = 32;
  localparam int unsigned StrideReset  = 640;

endpackage

@@ rtl/rasg_if.sv @@
interface rasg_cmd_if #(
  parameter int unsigned CB = 12,
  parameter int unsigned RB = 10
);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [CB-1:0]         center_x;
  logic [CB-1:0]         center_y;
  logic [RB-1:0]         outer_radius;
  logic [RB-1:0]         inner_radius;
  logic [3:0]            quadrant_mask;
  logic signed [RB:0]    offset;
  logic [rasg_pkg::ColorW-1:0] fill_color;

  modport source (output valid, mode, center_x, center_y, outer_radius, inner_radius,
                  quadrant_mask, offset, fill_color, input ready);
  modport sink (input valid, mode, center_x, center_y, outer_radius, inner_radius,
                quadrant_mask, offset, fill_color, output ready);
endinterface

interface rasg_span_if #(
  parameter int unsigned CB = 12
);
  logic                    valid;
  logic                    ready;
  logic signed [2*CB:0]    span_start;
  logic signed [2*CB:0]    span_end;
  logic                    vertical;
  logic [rasg_pkg::ColorW-1:0] span_color;
  logic                    last;

  modport source (output valid, span_start, span_end, vertical, span_color, last,
                  input ready);
  modport sink (input valid, span_start, span_end, vertical, span_color, last,
                output ready);
endinterface

interface rasg_cfg_if #(
  parameter int unsigned CB = 12
);
  logic                          valid;
  logic                          ready;
  logic [rasg_pkg::CfgIdxW-1:0]  index;
  logic [CB:0]                   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/ring_arc_span_generator.sv @@
// Ring arc span generator: one ring row or column command per request in, zero to two
// framebuffer address spans out. The pipeline is fully streamed and takes one command
// per cycle while the output buffer has room; a command that yields two spans holds
// the input while both wait there. Commands pass stages 1 and 2, the square-root cell
// chain that resolves one root bit per cell, stages 3 and 4, and the output buffer.
// Configuration registers are written through the configuration channel, always ready.
module ring_arc_span_generator #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rasg_cfg_if.sink    cfg_i,
  rasg_cmd_if.sink    cmd_i,
  rasg_span_if.source span_o
);
  `include "ring_arc_span_generator_assert.svh"

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned RB = RADIUS_BITS;
  localparam int unsigned RW = 2 * RB;
  localparam int unsigned AW = 2 * CB + 1;
  localparam int unsigned PW = ((CB > RB) ? CB : RB) + 2;
  localparam int unsigned FW = CB + PW + 3;
  localparam int unsigned CW = rasg_pkg::ColorW;
  localparam int unsigned PL = 1 + 2 * CB + 4 + (RB + 1) + CW + 1;

  // Configuration registers
  logic [CB-1:0] clip_left_q, clip_top_q;
  logic [CB:0]   clip_right_q, clip_bottom_q, line_stride_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= '0;
      clip_right_q  <= (CB+1)'(1) << CB;
      clip_top_q    <= '0;
      clip_bottom_q <= (CB+1)'(1) << CB;
      line_stride_q <= (CB+1)'(rasg_pkg::StrideReset);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rasg_pkg::CFG_CLIP_LEFT:   clip_left_q   <= cfg_i.data[CB-1:0];
        rasg_pkg::CFG_CLIP_RIGHT:  clip_right_q  <= cfg_i.data;
        rasg_pkg::CFG_CLIP_TOP:    clip_top_q    <= cfg_i.data[CB-1:0];
        rasg_pkg::CFG_CLIP_BOTTOM: clip_bottom_q <= cfg_i.data;
        rasg_pkg::CFG_LINE_STRIDE: line_stride_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Pipeline enable: move when the output buffer will have room
  logic en;
  logic vb0_q, vb1_q;
  logic out_fire;

  assign out_fire    = span_o.valid && span_o.ready;
  assign en          = !(vb0_q || vb1_q) || (out_fire && !(vb0_q && vb1_q));
  assign cmd_i.ready = en;

  // Stage 1: squares of the radii and the offset
  logic [RB:0]   off_abs;
  logic [RW:0]   sqf_d;
  logic          v1_q;
  logic [RW-1:0] sqo_q, sqi_q;
  logic [RW:0]   sqf_q;
  logic [PL-1:0] pl1_q;

  always_comb begin
    off_abs = cmd_i.offset[RB] ? (RB+1)'(-cmd_i.offset) : (RB+1)'(cmd_i.offset);
    sqf_d   = (RW+1)'(off_abs) * (RW+1)'(off_abs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqo_q <= RW'(cmd_i.outer_radius) * RW'(cmd_i.outer_radius);
      sqi_q <= RW'(cmd_i.inner_radius) * RW'(cmd_i.inner_radius);
      sqf_q <= sqf_d;
      pl1_q <= {cmd_i.mode, cmd_i.center_x, cmd_i.center_y, cmd_i.quadrant_mask,
                cmd_i.offset, cmd_i.fill_color, 1'b0};
    end
  end

  // Stage 2: radicands, clamp negatives, flag the hole
  logic [RW+1:0] dif_o, dif_i;
  logic          v2_q;
  logic [RW-1:0] rado_q, radi_q;
  logic [PL-1:0] pl2_q;

  always_comb begin
    dif_o = (RW+2)'(sqo_q) - (RW+2)'(sqf_q);
    dif_i = (RW+2)'(sqi_q) - (RW+2)'(sqf_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rado_q <= dif_o[RW+1] ? '0 : dif_o[RW-1:0];
      radi_q <= dif_i[RW+1] ? '0 : dif_i[RW-1:0];
      pl2_q  <= {pl1_q[PL-1:1], !dif_i[RW+1]};
    end
  end

  // Root cell chain, most significant root bit first
  logic          cv [RB+1];
  logic [RB-1:0] cqo [RB+1];
  logic [RW-1:0] cro [RB+1];
  logic [RB-1:0] cqi [RB+1];
  logic [RW-1:0] cri [RB+1];
  logic [PL-1:0] cpl [RB+1];

  assign cv[0]  = v2_q;
  assign cqo[0] = '0;
  assign cro[0] = rado_q;
  assign cqi[0] = '0;
  assign cri[0] = radi_q;
  assign cpl[0] = pl2_q;

  for (genvar g = 0; g < RB; g++) begin : g_cell
    rasg_root_cell #(
      .RB (RB),
      .K  (RB - 1 - g),
      .PL (PL)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[g]),
      .qo_i    (cqo[g]),
      .ro_i    (cro[g]),
      .qi_i    (cqi[g]),
      .ri_i    (cri[g]),
      .pl_i    (cpl[g]),
      .valid_o (cv[g+1]),
      .qo_o    (cqo[g+1]),
      .ro_o    (cro[g+1]),
      .qi_o    (cqi[g+1]),
      .ri_o    (cri[g+1]),
      .pl_o    (cpl[g+1])
    );
  end

  // Stage 3: round roots, form edges and clip
  logic                 p_mode, p_hole;
  logic [CB-1:0]        p_cx, p_cy;
  logic [3:0]           p_qm;
  logic signed [RB:0]   p_off;
  logic [CW-1:0]        p_color;
  logic signed [PW-1:0] w, lane, center, along, lo, hi, lob, hib;
  logic                 show_lo, show_hi;

  always_comb begin
    {p_mode, p_cx, p_cy, p_qm, p_off, p_color, p_hole} = cpl[RB];
    w    = PW'(cqo[RB]) + PW'((RW)'(cqo[RB]) < cro[RB]) - PW'(1);
    lane = PW'(cqi[RB]) + PW'((RW)'(cqi[RB]) < cri[RB]);
    if (p_mode) begin
      show_lo = !p_qm[rasg_pkg::QM_HIDE_TOP];
      show_hi = !p_qm[rasg_pkg::QM_HIDE_BOTTOM];
      center  = PW'(p_cy);
      along   = PW'(p_cx) + PW'(p_off);
      lob     = PW'(clip_top_q);
      hib     = PW'(clip_bottom_q);
    end else begin
      show_lo = !p_qm[rasg_pkg::QM_HIDE_LEFT];
      show_hi = !p_qm[rasg_pkg::QM_HIDE_RIGHT];
      center  = PW'(p_cx);
      along   = PW'(p_cy) + PW'(p_off);
      lob     = PW'(clip_left_q);
      hib     = PW'(clip_right_q);
    end
    lo = show_lo ? center - w : center;
    hi = show_hi ? center + w : center;
    if (lo < lob) lo = lob;
    if (hi >= hib) hi = hib - PW'(1);
  end

  logic                 v3_q;
  logic signed [PW-1:0] lo3_q, hi3_q, hl3_q, hh3_q, al3_q;
  logic                 mode3_q, slo3_q, shi3_q, hole3_q;
  logic [CW-1:0]        col3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= cv[RB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lo3_q   <= lo;
      hi3_q   <= hi;
      hl3_q   <= center - lane;
      hh3_q   <= center + lane;
      al3_q   <= along;
      mode3_q <= p_mode;
      slo3_q  <= show_lo;
      shi3_q  <= show_hi;
      hole3_q <= p_hole;
      col3_q  <= p_color;
    end
  end

  // Stage 4: stride products for the four addresses
  logic signed [FW-1:0] stride_s;
  logic                 v4_q;
  logic signed [FW-1:0] ps_q, pe_q, pl_q, ph_q;
  logic signed [PW-1:0] as_q, ae_q, al_q, ah_q;
  logic                 mode4_q, slo4_q, shi4_q, hole4_q;
  logic [CW-1:0]        col4_q;

  assign stride_s = FW'(line_stride_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ps_q    <= stride_s * FW'(mode3_q ? lo3_q : al3_q);
      pe_q    <= stride_s * FW'(mode3_q ? hi3_q : al3_q);
      pl_q    <= stride_s * FW'(mode3_q ? hl3_q : al3_q);
      ph_q    <= stride_s * FW'(mode3_q ? hh3_q : al3_q);
      as_q    <= mode3_q ? al3_q : lo3_q;
      ae_q    <= mode3_q ? al3_q : hi3_q;
      al_q    <= mode3_q ? al3_q : hl3_q;
      ah_q    <= mode3_q ? al3_q : hh3_q;
      mode4_q <= mode3_q;
      slo4_q  <= slo3_q;
      shi4_q  <= shi3_q;
      hole4_q <= hole3_q;
      col4_q  <= col3_q;
    end
  end

  // Stage 5: addresses, drop empty spans, load the output buffer
  logic signed [FW-1:0] a_s, a_e, a_l, a_h;
  logic [AW-1:0]        s0, e0, s1, e1;
  logic                 val0, val1;

  always_comb begin
    a_s = ps_q + FW'(as_q);
    a_e = pe_q + FW'(ae_q);
    a_l = pl_q + FW'(al_q);
    a_h = ph_q + FW'(ah_q);
    s0  = a_s[AW-1:0];
    s1  = a_h[AW-1:0];
    e1  = a_e[AW-1:0];
    if (hole4_q) begin
      e0   = a_l[AW-1:0];
      val0 = slo4_q && (a_s <= a_l);
      val1 = shi4_q && (a_h <= a_e);
    end else begin
      e0   = a_e[AW-1:0];
      val0 = a_s <= a_e;
      val1 = 1'b0;
    end
  end

  logic [AW-1:0] b0s_q, b0e_q, b1s_q, b1e_q;
  logic          bmode_q;
  logic [CW-1:0] bcol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb0_q <= 1'b0;
      vb1_q <= 1'b0;
    end else if (en) begin
      vb0_q <= v4_q && val0;
      vb1_q <= v4_q && val1;
    end else if (out_fire) begin
      if (vb0_q) vb0_q <= 1'b0;
      else vb1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0s_q   <= s0;
      b0e_q   <= e0;
      b1s_q   <= s1;
      b1e_q   <= e1;
      bmode_q <= mode4_q;
      bcol_q  <= col4_q;
    end
  end

  // Present the first pending span
  assign span_o.valid      = vb0_q || vb1_q;
  assign span_o.span_start = vb0_q ? b0s_q : b1s_q;
  assign span_o.span_end   = vb0_q ? b0e_q : b1e_q;
  assign span_o.vertical   = bmode_q;
  assign span_o.span_color = bcol_q;
  assign span_o.last       = !(vb0_q && vb1_q);

  `RASG_ASSERT(a_full_blocks, clk_i, rst_ni, (vb0_q && vb1_q) |-> !en, "full buffer must stall")
  `RASG_ASSERT(a_empty_moves, clk_i, rst_ni, !(vb0_q || vb1_q) |-> en, "empty buffer must not stall")
  `RASG_ASSERT(a_stall_holds, clk_i, rst_ni, !en |=> $stable(v4_q), "stage moved during stall")
endmodule

@@ rtl/rasg_root_cell.sv @@
// One result bit of two digit-by-digit square roots, with payload riding along.
module rasg_root_cell #(
  parameter int unsigned RB = 10,
  parameter int unsigned K  = 0,
  parameter int unsigned PL = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [RB-1:0]   qo_i,
  input  logic [2*RB-1:0] ro_i,
  input  logic [RB-1:0]   qi_i,
  input  logic [2*RB-1:0] ri_i,
  input  logic [PL-1:0]   pl_i,
  output logic            valid_o,
  output logic [RB-1:0]   qo_o,
  output logic [2*RB-1:0] ro_o,
  output logic [RB-1:0]   qi_o,
  output logic [2*RB-1:0] ri_o,
  output logic [PL-1:0]   pl_o
);
  localparam int unsigned RW = 2 * RB;

  logic [RW:0]    to, ti;
  logic           go, gi;
  logic [RB-1:0]  qo_d, qi_d;
  logic [RW-1:0]  ro_d, ri_d;
  logic           valid_q;
  logic [RB-1:0]  qo_q, qi_q;
  logic [RW-1:0]  ro_q, ri_q;
  logic [PL-1:0]  pl_q;

  // Try setting bit K: cost is 2*q*2^K + 4^K
  always_comb begin
    to   = ((RW+1)'(qo_i) << (K + 1)) + ((RW+1)'(1) << (2 * K));
    ti   = ((RW+1)'(qi_i) << (K + 1)) + ((RW+1)'(1) << (2 * K));
    go   = {1'b0, ro_i} >= to;
    gi   = {1'b0, ri_i} >= ti;
    qo_d = go ? (qo_i | (RB'(1) << K)) : qo_i;
    qi_d = gi ? (qi_i | (RB'(1) << K)) : qi_i;
    ro_d = go ? RW'({1'b0, ro_i} - to) : ro_i;
    ri_d = gi ? RW'({1'b0, ri_i} - ti) : ri_i;
  end

  // Advance valid with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Hand partial roots to the next cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qo_q <= qo_d;
      qi_q <= qi_d;
      ro_q <= ro_d;
      ri_q <= ri_d;
      pl_q <= pl_i;
    end
  end

  assign valid_o = valid_q;
  assign qo_o    = qo_q;
  assign ro_o    = ro_q;
  assign qi_o    = qi_q;
  assign ri_o    = ri_q;
  assign pl_o    = pl_q;
endmodule
